// ===== rtl/core/irm_pkg.sv =====
// Shared types and constants for the image region mask block.
package irm_pkg;

  // Configuration port geometry
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 33;

  // Fixed field widths
  localparam int unsigned PixW      = 32;
  localparam int unsigned BoundW    = 16;
  localparam int unsigned RadSqW    = 33;
  localparam int unsigned CtrlW     = 4;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegControl      = 3'd0;
  localparam logic [CfgIdxW-1:0] RegXLow         = 3'd1;
  localparam logic [CfgIdxW-1:0] RegXHigh        = 3'd2;
  localparam logic [CfgIdxW-1:0] RegYLow         = 3'd3;
  localparam logic [CfgIdxW-1:0] RegYHigh        = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCircleCenter = 3'd5;
  localparam logic [CfgIdxW-1:0] RegRadiusSq     = 3'd6;
  localparam logic [CfgIdxW-1:0] RegFillValue    = 3'd7;

  // Operation applied to a selected pixel
  typedef enum logic [1:0] {
    OP_SET     = 2'd0,
    OP_ADD     = 2'd1,
    OP_MUL     = 2'd2,
    OP_SET_ALT = 2'd3
  } op_e;

  // Region description seen by the selection logic
  typedef struct packed {
    logic                   circle;
    logic                   invert;
    logic [BoundW-1:0]      x_low;
    logic [BoundW-1:0]      x_high;
    logic [BoundW-1:0]      y_low;
    logic [BoundW-1:0]      y_high;
    logic [BoundW-1:0]      cx;
    logic [BoundW-1:0]      cy;
    logic [RadSqW-1:0]      radius_sq;
  } region_cfg_t;

endpackage

// ===== rtl/core/irm_coord_cnt.sv =====
// Column and row position counter for the raster pixel stream.
module irm_coord_cnt #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  logic                  row_end_i,
  input  logic                  frame_end_i,
  output logic [COORD_BITS-1:0] col_o,
  output logic [COORD_BITS-1:0] row_o
);

  logic [COORD_BITS-1:0] col_q, col_d;
  logic [COORD_BITS-1:0] row_q, row_d;

  // Next position: frame end wins over row end, counters wrap
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (advance_i) begin
      if (frame_end_i) begin
        col_d = '0;
        row_d = '0;
      end else if (row_end_i) begin
        col_d = '0;
        row_d = row_q + COORD_BITS'(1);
      end else begin
        col_d = col_q + COORD_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o = col_q;
  assign row_o = row_q;

endmodule

// ===== rtl/core/irm_region.sv =====
// Box or circle membership test for one pixel position.
module irm_region #(
  parameter int unsigned COORD_BITS = 16
) (
  input  irm_pkg::region_cfg_t  cfg_i,
  input  logic [COORD_BITS-1:0] col_i,
  input  logic [COORD_BITS-1:0] row_i,
  output logic                  sel_o
);

  logic [irm_pkg::BoundW-1:0]   col;
  logic [irm_pkg::BoundW-1:0]   row;
  logic                         in_box;
  logic [irm_pkg::BoundW-1:0]   dx_abs;
  logic [irm_pkg::BoundW-1:0]   dy_abs;
  logic [2*irm_pkg::BoundW-1:0] dx_sq;
  logic [2*irm_pkg::BoundW-1:0] dy_sq;
  logic [irm_pkg::RadSqW-1:0]   dist_sq;

  assign col = irm_pkg::BoundW'(col_i);
  assign row = irm_pkg::BoundW'(row_i);

  // Box: low bound inclusive, high bound exclusive
  assign in_box = (col >= cfg_i.x_low) && (col < cfg_i.x_high) &&
                  (row >= cfg_i.y_low) && (row < cfg_i.y_high);

  // Circle: exact squared distance from the centre
  assign dx_abs  = (col >= cfg_i.cx) ? (col - cfg_i.cx) : (cfg_i.cx - col);
  assign dy_abs  = (row >= cfg_i.cy) ? (row - cfg_i.cy) : (cfg_i.cy - row);
  assign dx_sq   = dx_abs * dx_abs;
  assign dy_sq   = dy_abs * dy_abs;
  assign dist_sq = irm_pkg::RadSqW'(dx_sq) + irm_pkg::RadSqW'(dy_sq);

  // The circle boundary is selected both plain and inverted
  always_comb begin
    if (cfg_i.circle) begin
      sel_o = cfg_i.invert ? (dist_sq >= cfg_i.radius_sq) : (dist_sq <= cfg_i.radius_sq);
    end else begin
      sel_o = cfg_i.invert ? !in_box : in_box;
    end
  end

endmodule

// ===== rtl/core/irm_pixel_op.sv =====
// Set, saturating add or saturating Q16.16 multiply of a selected pixel.
module irm_pixel_op (
  input  logic signed [irm_pkg::PixW-1:0] pixel_i,
  input  logic signed [irm_pkg::PixW-1:0] fill_i,
  input  irm_pkg::op_e                    op_i,
  input  logic                            sel_i,
  output logic signed [irm_pkg::PixW-1:0] pixel_o
);

  localparam int unsigned SumW  = irm_pkg::PixW + 1;
  localparam int unsigned ProdW = 2 * irm_pkg::PixW;
  localparam int unsigned FracW = 16;
  localparam int unsigned ShW   = ProdW - FracW;

  localparam logic signed [irm_pkg::PixW-1:0] PixMax = {1'b0, {(irm_pkg::PixW-1){1'b1}}};
  localparam logic signed [irm_pkg::PixW-1:0] PixMin = {1'b1, {(irm_pkg::PixW-1){1'b0}}};

  logic signed [SumW-1:0]          sum;
  logic signed [irm_pkg::PixW-1:0] sum_sat;
  logic signed [ProdW-1:0]         pix_ext;
  logic signed [ProdW-1:0]         fill_ext;
  logic signed [ProdW-1:0]         prod;
  logic signed [ShW-1:0]           prod_sh;
  logic                            prod_fits;
  logic signed [irm_pkg::PixW-1:0] prod_sat;

  // Saturating add
  assign sum = SumW'(pixel_i) + SumW'(fill_i);
  always_comb begin
    if (sum[SumW-1] != sum[SumW-2]) begin
      sum_sat = sum[SumW-1] ? PixMin : PixMax;
    end else begin
      sum_sat = sum[irm_pkg::PixW-1:0];
    end
  end

  // Full product, arithmetic shift drops the fraction (floor), then saturate
  assign pix_ext   = ProdW'(pixel_i);
  assign fill_ext  = ProdW'(fill_i);
  assign prod      = pix_ext * fill_ext;
  assign prod_sh   = prod[ProdW-1:FracW];
  assign prod_fits = (&prod_sh[ShW-1:irm_pkg::PixW-1]) || !(|prod_sh[ShW-1:irm_pkg::PixW-1]);
  always_comb begin
    if (prod_fits) begin
      prod_sat = prod_sh[irm_pkg::PixW-1:0];
    end else begin
      prod_sat = prod_sh[ShW-1] ? PixMin : PixMax;
    end
  end

  // Unselected pixels pass through
  always_comb begin
    pixel_o = pixel_i;
    if (sel_i) begin
      case (op_i) inside
        irm_pkg::OP_ADD: begin
          pixel_o = sum_sat;
        end
        irm_pkg::OP_MUL: begin
          pixel_o = prod_sat;
        end
        irm_pkg::OP_SET, irm_pkg::OP_SET_ALT: begin
          pixel_o = fill_i;
        end
        default: begin
          pixel_o = fill_i;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/image_region_mask.sv =====
// Top level of the image region mask: config registers, pixel pipeline, output register.
//
// Usage:
//   Pixels arrive in raster order on the input channel (in_valid_i / in_stall_o) as
//   signed Q16.16 words with row end and frame end flags on the last pixel of a row
//   or image. The block counts its own column and row from these flags.
//   Each pixel is tested against a box or a circle (or the complement) and a
//   selected pixel is set to, added to or multiplied by the fill value.
//   Results leave on the output channel (out_valid_o / out_stall_i), one word per
//   input word, in order, with the flags copied through.
// Timing:
//   An accepted word passes through the input register and then the output
//   register before it is presented on the output.
//   One word per cycle is sustained while out_stall_i is low; the cycle is set
//   by the 32x32 multiply and saturation between the input and output registers.
// Reset:
//   All configuration registers and both counters clear; the pipeline empties.
// Stall:
//   While out_stall_i holds, the output word holds; the input register still fills, and
//   once both are full in_stall_o is raised in the same cycle. The user must write
//   configuration via cfg_we_i / cfg_idx_i / cfg_wdata_i only while idle (not enforced).
module image_region_mask #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic [irm_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [irm_pkg::CfgDataW-1:0]        cfg_wdata_i,
  // Input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [irm_pkg::PixW-1:0]     pixel_in_i,
  input  logic                                row_end_in_i,
  input  logic                                frame_end_in_i,
  // Output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [irm_pkg::PixW-1:0]     pixel_out_o,
  output logic                                row_end_out_o,
  output logic                                frame_end_out_o
);

  irm_pkg::region_cfg_t            region_q;
  irm_pkg::op_e                    op_q;
  logic signed [irm_pkg::PixW-1:0] fill_q;

  logic                            in_accept;
  logic                            out_load;
  logic [COORD_BITS-1:0]           col;
  logic [COORD_BITS-1:0]           row;

  logic                            s1_valid_q;
  logic signed [irm_pkg::PixW-1:0] s1_pixel_q;
  logic                            s1_row_end_q;
  logic                            s1_frame_end_q;
  logic [COORD_BITS-1:0]           s1_col_q;
  logic [COORD_BITS-1:0]           s1_row_q;

  logic                            sel;
  logic signed [irm_pkg::PixW-1:0] pixel_res;

  logic                            out_valid_q;
  logic signed [irm_pkg::PixW-1:0] out_pixel_q;
  logic                            out_row_end_q;
  logic                            out_frame_end_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q <= '0;
      op_q     <= irm_pkg::OP_SET;
      fill_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        irm_pkg::RegControl: begin
          region_q.circle <= cfg_wdata_i[0];
          region_q.invert <= cfg_wdata_i[1];
          op_q            <= irm_pkg::op_e'(cfg_wdata_i[3:2]);
        end
        irm_pkg::RegXLow:         region_q.x_low     <= cfg_wdata_i[irm_pkg::BoundW-1:0];
        irm_pkg::RegXHigh:        region_q.x_high    <= cfg_wdata_i[irm_pkg::BoundW-1:0];
        irm_pkg::RegYLow:         region_q.y_low     <= cfg_wdata_i[irm_pkg::BoundW-1:0];
        irm_pkg::RegYHigh:        region_q.y_high    <= cfg_wdata_i[irm_pkg::BoundW-1:0];
        irm_pkg::RegCircleCenter: begin
          region_q.cx <= cfg_wdata_i[irm_pkg::BoundW-1:0];
          region_q.cy <= cfg_wdata_i[2*irm_pkg::BoundW-1:irm_pkg::BoundW];
        end
        irm_pkg::RegRadiusSq:     region_q.radius_sq <= cfg_wdata_i[irm_pkg::RadSqW-1:0];
        irm_pkg::RegFillValue:    fill_q             <= cfg_wdata_i[irm_pkg::PixW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline flow: output loads when empty or taken, input register moves into it
  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_load;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Position of the word being accepted
  irm_coord_cnt #(
    .COORD_BITS (COORD_BITS)
  ) u_coord_cnt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (in_accept),
    .row_end_i   (row_end_in_i),
    .frame_end_i (frame_end_in_i),
    .col_o       (col),
    .row_o       (row)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!s1_valid_q || out_load) begin
      s1_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pixel_q     <= pixel_in_i;
      s1_row_end_q   <= row_end_in_i;
      s1_frame_end_q <= frame_end_in_i;
      s1_col_q       <= col;
      s1_row_q       <= row;
    end
  end

  // Region test and pixel operation
  irm_region #(
    .COORD_BITS (COORD_BITS)
  ) u_region (
    .cfg_i (region_q),
    .col_i (s1_col_q),
    .row_i (s1_row_q),
    .sel_o (sel)
  );

  irm_pixel_op u_pixel_op (
    .pixel_i (s1_pixel_q),
    .fill_i  (fill_q),
    .op_i    (op_q),
    .sel_i   (sel),
    .pixel_o (pixel_res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s1_valid_q) begin
      out_pixel_q     <= pixel_res;
      out_row_end_q   <= s1_row_end_q;
      out_frame_end_q <= s1_frame_end_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_out_o     = out_pixel_q;
  assign row_end_out_o   = out_row_end_q;
  assign frame_end_out_o = out_frame_end_q;

endmodule

// ===== bench/image_region_mask_tb.sv =====
// Self-checking testbench for the image region mask: directed and random pixel streams.
module image_region_mask_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CoordBits   = 16;
  localparam logic [irm_pkg::RadSqW-1:0] RadSqMax = 33'd8589672450;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned RandomItems = 1450;

  // One word on either channel
  typedef struct packed {
    logic [irm_pkg::PixW-1:0] pixel;
    logic                     row_end;
    logic                     frame_end;
  } pixel_word_t;

  // Tracks the region registers and raster position, and holds the masked pixels due out
  class pixel_mask_tracker;
    logic [irm_pkg::CtrlW-1:0]  control;
    logic [irm_pkg::BoundW-1:0] x_low, x_high, y_low, y_high;
    logic [irm_pkg::PixW-1:0]   centre;
    logic [irm_pkg::RadSqW-1:0] radius_sq;
    logic [irm_pkg::PixW-1:0]   fill;
    logic [CoordBits-1:0]       col_count, row_count;
    pixel_word_t                awaited_pixels[$];
    int unsigned                mismatches;

    function new();
      control   = '0;
      x_low     = '0;
      x_high    = '0;
      y_low     = '0;
      y_high    = '0;
      centre    = '0;
      radius_sq = '0;
      fill      = '0;
      col_count = '0;
      row_count = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [irm_pkg::CfgIdxW-1:0] idx,
                            logic [irm_pkg::CfgDataW-1:0] data);
      case (idx)
        irm_pkg::RegControl:      control   = data[irm_pkg::CtrlW-1:0];
        irm_pkg::RegXLow:         x_low     = data[irm_pkg::BoundW-1:0];
        irm_pkg::RegXHigh:        x_high    = data[irm_pkg::BoundW-1:0];
        irm_pkg::RegYLow:         y_low     = data[irm_pkg::BoundW-1:0];
        irm_pkg::RegYHigh:        y_high    = data[irm_pkg::BoundW-1:0];
        irm_pkg::RegCircleCenter: centre    = data[irm_pkg::PixW-1:0];
        irm_pkg::RegRadiusSq:     radius_sq = data[irm_pkg::RadSqW-1:0];
        irm_pkg::RegFillValue:    fill      = data[irm_pkg::PixW-1:0];
        default: ;
      endcase
    endfunction

    // Box or circle test at the current position; the circle boundary is in both senses
    function bit in_region();
      longint dx, dy, dist_sq, rsq;
      bit     in_box;
      if (control[0]) begin
        dx      = longint'(centre[15:0]) - longint'(col_count);
        dy      = longint'(centre[31:16]) - longint'(row_count);
        dist_sq = dx * dx + dy * dy;
        rsq     = longint'(radius_sq);
        return control[1] ? (dist_sq >= rsq) : (dist_sq <= rsq);
      end
      in_box = col_count >= x_low && col_count < x_high &&
               row_count >= y_low && row_count < y_high;
      return control[1] ^ in_box;
    endfunction

    function logic [irm_pkg::PixW-1:0] clamp32(longint v);
      if (v > longint'(32'sh7FFF_FFFF)) return 32'h7FFF_FFFF;
      if (v < -longint'(64'h8000_0000)) return 32'h8000_0000;
      return v[irm_pkg::PixW-1:0];
    endfunction

    // Work out the masked pixel for an accepted word, then step the raster position
    function void note_input(logic [irm_pkg::PixW-1:0] pixel, logic row_end, logic frame_end);
      pixel_word_t  result;
      longint       pix, operand;
      irm_pkg::op_e op;
      pix     = longint'($signed(pixel));
      operand = longint'($signed(fill));
      result.pixel     = pixel;
      result.row_end   = row_end;
      result.frame_end = frame_end;
      if (in_region()) begin
        op = irm_pkg::op_e'(control[3:2]);
        case (op)
          irm_pkg::OP_ADD: result.pixel = clamp32(pix + operand);
          irm_pkg::OP_MUL: result.pixel = clamp32((pix * operand) >>> 16);  // floor
          default:         result.pixel = fill;
        endcase
      end
      awaited_pixels.push_back(result);

      if (frame_end) begin
        col_count = '0;
        row_count = '0;
      end else if (row_end) begin
        col_count = '0;
        row_count = row_count + 1'b1;
      end else begin
        col_count = col_count + 1'b1;
      end
    endfunction

    function void flag(string field, logic [irm_pkg::PixW-1:0] want,
                       logic [irm_pkg::PixW-1:0] got);
      mismatches++;
      $display("%0t: %s expected %h got %h", $time, field, want, got);
    endfunction

    function void check_output(logic [irm_pkg::PixW-1:0] pixel, logic row_end,
                               logic frame_end);
      pixel_word_t want;
      if (awaited_pixels.size() == 0) begin
        mismatches++;
        $display("%0t: word expected none got pixel %h row_end %b frame_end %b",
                 $time, pixel, row_end, frame_end);
        return;
      end
      want = awaited_pixels.pop_front();
      if (pixel !== want.pixel)
        flag("pixel_out", want.pixel, pixel);
      if (row_end !== want.row_end)
        flag("row_end_out", irm_pkg::PixW'(want.row_end), irm_pkg::PixW'(row_end));
      if (frame_end !== want.frame_end)
        flag("frame_end_out", irm_pkg::PixW'(want.frame_end), irm_pkg::PixW'(frame_end));
    endfunction

    function int unsigned pending();
      return awaited_pixels.size();
    endfunction
  endclass

  logic                              clk_i          = 1'b0;
  logic                              rst_ni         = 1'b0;
  logic                              cfg_we_i       = 1'b0;
  logic [irm_pkg::CfgIdxW-1:0]       cfg_idx_i      = '0;
  logic [irm_pkg::CfgDataW-1:0]      cfg_wdata_i    = '0;
  logic                              in_valid_i     = 1'b0;
  logic                              in_stall_o;
  logic signed [irm_pkg::PixW-1:0]   pixel_in_i     = '0;
  logic                              row_end_in_i   = 1'b0;
  logic                              frame_end_in_i = 1'b0;
  logic                              out_valid_o;
  logic                              out_stall_i    = 1'b0;
  logic signed [irm_pkg::PixW-1:0]   pixel_out_o;
  logic                              row_end_out_o;
  logic                              frame_end_out_o;

  int unsigned          sender_idle_pct    = 0;
  int unsigned          receiver_stall_pct = 0;
  int unsigned          random_sent        = 0;
  int unsigned          cycle_count        = 0;
  pixel_mask_tracker    tracker;

  image_region_mask #(
    .COORD_BITS(CoordBits)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_in_i     (pixel_in_i),
    .row_end_in_i   (row_end_in_i),
    .frame_end_in_i (frame_end_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_out_o    (pixel_out_o),
    .row_end_out_o  (row_end_out_o),
    .frame_end_out_o(frame_end_out_o)
  );

  always #4 clk_i = ~clk_i;

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Outputs are steady mid-cycle; a word seen valid and unstalled here is taken at the next edge
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_output(pixel_out_o, row_end_out_o, frame_end_out_o);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one word, with a random gap first; returns at the edge that takes it
  task automatic send_pixel(input logic [irm_pkg::PixW-1:0] pixel, input logic row_end,
                            input logic frame_end);
    logic stalled;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    pixel_in_i     <= pixel;
    row_end_in_i   <= row_end;
    frame_end_in_i <= frame_end;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    tracker.note_input(pixel, row_end, frame_end);
  endtask

  // Stop offering and wait for every masked pixel to come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [irm_pkg::CfgIdxW-1:0] idx,
                           input logic [irm_pkg::CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    tracker.write_reg(idx, data);
  endtask

  // Load the whole region description; only called with the block idle
  task automatic program_region(input logic [irm_pkg::CtrlW-1:0] ctrl,
                                input logic [irm_pkg::BoundW-1:0] xl,
                                input logic [irm_pkg::BoundW-1:0] xh,
                                input logic [irm_pkg::BoundW-1:0] yl,
                                input logic [irm_pkg::BoundW-1:0] yh,
                                input logic [irm_pkg::PixW-1:0] ctr,
                                input logic [irm_pkg::RadSqW-1:0] rsq,
                                input logic [irm_pkg::PixW-1:0] fill);
    write_reg(irm_pkg::RegControl, irm_pkg::CfgDataW'(ctrl));
    write_reg(irm_pkg::RegXLow, irm_pkg::CfgDataW'(xl));
    write_reg(irm_pkg::RegXHigh, irm_pkg::CfgDataW'(xh));
    write_reg(irm_pkg::RegYLow, irm_pkg::CfgDataW'(yl));
    write_reg(irm_pkg::RegYHigh, irm_pkg::CfgDataW'(yh));
    write_reg(irm_pkg::RegCircleCenter, irm_pkg::CfgDataW'(ctr));
    write_reg(irm_pkg::RegRadiusSq, irm_pkg::CfgDataW'(rsq));
    write_reg(irm_pkg::RegFillValue, irm_pkg::CfgDataW'(fill));
    cfg_we_i <= 1'b0;
  endtask

  // Pixel or fill value, weighted towards the saturation corners and small magnitudes
  function automatic logic [irm_pkg::PixW-1:0] rand_word();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [irm_pkg::BoundW-1:0] rand_bound();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 16'hFFFF;
      default: return irm_pkg::BoundW'($urandom_range(0, 14));
    endcase
  endfunction

  function automatic logic [irm_pkg::RadSqW-1:0] rand_radius_sq();
    logic [irm_pkg::RadSqW-1:0] rsq;
    case ($urandom_range(7))
      0: rsq = '0;
      1: rsq = RadSqMax;
      2: begin
        rsq = {1'($urandom_range(1)), 32'($urandom)};
        if (rsq > RadSqMax) rsq = RadSqMax;
      end
      default: rsq = irm_pkg::RadSqW'($urandom_range(0, 150));
    endcase
    return rsq;
  endfunction

  task automatic program_random_region();
    logic [irm_pkg::CtrlW-1:0]  ctrl;
    logic [irm_pkg::BoundW-1:0] cx, cy;
    ctrl = {irm_pkg::op_e'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1))};
    cx   = ($urandom_range(7) == 0) ? 16'hFFFF : irm_pkg::BoundW'($urandom_range(0, 14));
    cy   = ($urandom_range(7) == 0) ? 16'hFFFF : irm_pkg::BoundW'($urandom_range(0, 10));
    program_region(ctrl, rand_bound(), rand_bound(), rand_bound(), rand_bound(),
                   {cy, cx}, rand_radius_sq(), rand_word());
  endtask

  // Mostly well-formed frames; now and then flags are scattered at random
  task automatic send_frame();
    int unsigned width, height;
    bit          noisy;
    logic        row_end, frame_end;
    width  = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    height = $urandom_range(1, 8);
    noisy  = ($urandom_range(9) == 0);
    for (int unsigned r = 0; r < height; r++) begin
      for (int unsigned c = 0; c < width; c++) begin
        frame_end = (r == height - 1) && (c == width - 1);
        row_end   = (c == width - 1) && (!frame_end || $urandom_range(3) != 0);
        if (noisy) begin
          row_end   = ($urandom_range(7) == 0);
          frame_end = ($urandom_range(15) == 0);
        end
        send_pixel(rand_word(), row_end, frame_end);
        random_sent++;
      end
    end
  endtask

  initial begin
    tracker = new();
    sender_idle_pct    = 38;
    receiver_stall_pct = 67;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: empty box, so everything passes through
    send_pixel(32'h7FFF_FFFF, 1'b0, 1'b0);
    send_pixel(32'h8000_0000, 1'b0, 1'b0);
    send_pixel(32'h0000_0000, 1'b1, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b1, 1'b1);
    drain();

    // Add into a 2x2 box, with overflow at the positive limit
    program_region({irm_pkg::OP_ADD, 1'b0, 1'b0}, 16'd0, 16'd2, 16'd0, 16'd2,
                   32'h0, 33'd0, 32'h7FFF_FFFF);
    send_pixel(32'h7FFF_FFFF, 1'b0, 1'b0);
    send_pixel(32'h8000_0000, 1'b0, 1'b0);
    send_pixel(32'h0000_0005, 1'b1, 1'b0);
    send_pixel(32'h1234_5678, 1'b1, 1'b1);
    drain();

    // Reversed box inverted selects all; multiply saturates and truncates down
    program_region({irm_pkg::OP_MUL, 1'b1, 1'b0}, 16'd9, 16'd2, 16'hFFFF, 16'd0,
                   32'h0, 33'd0, 32'h8000_0001);
    send_pixel(32'h0000_0001, 1'b0, 1'b0);
    send_pixel(32'h8000_0000, 1'b0, 1'b0);
    send_pixel(32'h7FFF_FFFF, 1'b0, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b1, 1'b1);
    drain();

    // Inverted circle at the far corner: the largest distance sits on the boundary
    program_region({irm_pkg::OP_SET_ALT, 1'b1, 1'b1}, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   32'hFFFF_FFFF, RadSqMax, 32'h1234_5678);
    send_pixel(32'h0BAD_F00D, 1'b0, 1'b0);
    send_pixel(32'h0000_0042, 1'b0, 1'b1);
    drain();

    // Unit circle: boundary pixels are replaced
    program_region({irm_pkg::OP_SET, 1'b0, 1'b1}, 16'd0, 16'd0, 16'd0, 16'd0,
                   32'h0001_0001, 33'd1, 32'h8000_0000);
    send_pixel(32'h0000_1111, 1'b0, 1'b0);
    send_pixel(32'h0000_2222, 1'b0, 1'b0);
    send_pixel(32'h0000_3333, 1'b1, 1'b0);
    send_pixel(32'h0000_4444, 1'b1, 1'b1);
    drain();

    // Random regions and frames under three idling schemes
    while (random_sent < RandomItems) begin
      if (random_sent < RandomItems / 3) begin
        sender_idle_pct    = 38;
        receiver_stall_pct = 67;
      end else if (random_sent < 2 * RandomItems / 3) begin
        sender_idle_pct    = 67;
        receiver_stall_pct = 38;
      end else begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
      end
      program_random_region();
      repeat ($urandom_range(1, 3)) send_frame();
      drain();
    end

    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
